/* rtl/mdis_pkg.sv */
// package for the max-duration interval selection unit
// types, sizes and state codes; no dependencies
`default_nettype none
package mdis_pkg;
  localparam int unsigned MaxIntervals = 16;
  localparam int unsigned TimeBits     = 16;
  localparam int unsigned IdxW  = $clog2(MaxIntervals);
  localparam int unsigned CntW  = $clog2(MaxIntervals + 1);
  localparam int unsigned SumW  = 21;
  localparam int unsigned EntW  = 2 * TimeBits;

  typedef struct packed {
    logic [15:0] start_time;
    logic [15:0] end_time;
    logic        last;
  } in_item_t;

  typedef struct packed {
    logic [15:0] sel_start;
    logic [15:0] sel_end;
    logic [20:0] best_total;
    logic        none_found;
    logic        overflow;
    logic        final_res;
  } out_item_t;

  typedef enum logic [3:0] {
    StLoad, StCfI, StCfJ, StCfChk, StEnum, StEnumChk, StDecide,
    StEmitRd, StEmitWait, StEmit, StNone
  } state_e;
endpackage
`default_nettype wire

/* rtl/mdis_ram.sv */
// generic single-port synchronous ram with registered read
// no dependencies
`default_nettype none
module mdis_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end
endmodule
`default_nettype wire

/* rtl/max_duration_interval_selection_unit.sv */
// max-duration interval selection: loads intervals into a ram, then searches
// all subsets. depends on mdis_pkg and mdis_ram
//
// usage: intervals come in on the in channel, one item a cycle while loading.
// an item with last set starts the search; no new item is taken until the
// last result of that run has been placed in the output register. a pairwise
// conflict table is built by reading the ram (a read of i, a read of j and a
// check per pair), then each of the 2^n - 1 subsets is checked by reading
// and checking one interval at a time, with a compare step after each subset.
// the chosen intervals are then read back in index order through a read, a
// wait and an emit step each, unchosen indices being skipped in the read step.
// if no subset has a positive total one result with none_found set is given.
// items beyond sixteen are dropped and flagged. reset empties the store and
// returns to loading; ram contents are not cleared. a stalled receiver holds
// the output register and the next result waits behind it.
`default_nettype none
module max_duration_interval_selection_unit (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire mdis_pkg::in_item_t in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output mdis_pkg::out_item_t     out_data_o
);
  localparam int unsigned N = mdis_pkg::MaxIntervals;
  localparam int unsigned IW = mdis_pkg::IdxW;
  localparam int unsigned CW = mdis_pkg::CntW;
  localparam int unsigned SW = mdis_pkg::SumW;
  localparam int unsigned TB = mdis_pkg::TimeBits;

  mdis_pkg::state_e state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          ovf_q, ovf_d;
  logic [IW-1:0] i_q, i_d, j_q, j_d;
  logic [N-1:0]  conf_q [N];
  logic [N-1:0]  conf_d [N];
  logic [TB-1:0] si_q, si_d, ei_q, ei_d;
  logic [N-1:0]  cand_q, cand_d, best_q, best_d;
  logic [SW+1:0] sum_q, sum_d, bsum_q, bsum_d;
  logic          ok_q, ok_d;
  logic [CW-1:0] pc_q, pc_d, pb_q, pb_d;
  logic [CW-1:0] k_q, k_d;
  logic          ov_q, ov_d;
  mdis_pkg::out_item_t od_q, od_d;
  logic          ovl_q, ovl_d;

  logic          we;
  logic [IW-1:0] addr;
  logic [mdis_pkg::EntW-1:0] wdata, rdata;

  mdis_ram #(.Width(mdis_pkg::EntW), .Depth(N)) u_ram (
    .clk_i, .we_i(we), .addr_i(addr), .wdata_i(wdata), .rdata_o(rdata)
  );

  logic [TB-1:0] rs, re;
  logic [SW+1:0] dur;
  logic [N-1:0]  diff, lowb;
  logic [SW+1:0] tot_sat;
  logic          in_acc, out_free;

  assign rs   = rdata[TB-1:0];
  assign re   = rdata[2*TB-1:TB];
  assign dur  = (SW+2)'({2'b0, re}) - (SW+2)'({2'b0, rs});
  assign diff = cand_q ^ best_q;
  assign lowb = diff & (~diff + N'(1));
  assign tot_sat = ($signed(bsum_q) > $signed((SW+2)'(1048575))) ?
                   (SW+2)'(1048575) : bsum_q;
  assign in_acc   = in_valid_i && in_ready_o;
  assign out_free = !ovl_q || out_ready_i;

  always_comb begin
    state_d = state_q; cnt_d = cnt_q; ovf_d = ovf_q; i_d = i_q; j_d = j_q;
    conf_d = conf_q; si_d = si_q; ei_d = ei_q; cand_d = cand_q; best_d = best_q;
    sum_d = sum_q; bsum_d = bsum_q; ok_d = ok_q; pc_d = pc_q; pb_d = pb_q;
    k_d = k_q; ov_d = ov_q; od_d = od_q;
    ovl_d = ovl_q && !out_ready_i;
    we = 1'b0; addr = i_q; wdata = '0; in_ready_o = 1'b0;
    unique case (state_q)
      mdis_pkg::StLoad: begin
        in_ready_o = 1'b1;
        addr = cnt_q[IW-1:0];
        wdata = {TB'(in_data_i.end_time), TB'(in_data_i.start_time)};
        if (in_acc) begin
          if (cnt_q < CW'(N)) begin
            we = 1'b1; cnt_d = cnt_q + CW'(1);
          end else begin
            ovf_d = 1'b1;
          end
          if (in_data_i.last) begin
            ov_d = ovf_d || (cnt_q >= CW'(N));
            for (int a = 0; a < N; a++) conf_d[a] = '0;
            i_d = '0; j_d = IW'(1);
            state_d = mdis_pkg::StCfI;
          end
        end
      end
      // conflict table: read i, then each later j
      mdis_pkg::StCfI: begin
        if (CW'(j_q) >= cnt_d || j_q == '0) begin
          // no more pairs
          best_d = '0; bsum_d = '0; pb_d = '0; cand_d = N'(1);
          if (cnt_q == '0) state_d = mdis_pkg::StNone;
          else begin
            i_d = '0; sum_d = '0; ok_d = 1'b1; pc_d = '0;
            state_d = mdis_pkg::StEnum;
          end
        end else begin
          addr = i_q; state_d = mdis_pkg::StCfJ;
        end
      end
      mdis_pkg::StCfJ: begin
        si_d = rs; ei_d = re; addr = j_q; state_d = mdis_pkg::StCfChk;
      end
      mdis_pkg::StCfChk: begin
        if (si_q < re && rs < ei_q) begin
          conf_d[i_q][j_q] = 1'b1; conf_d[j_q][i_q] = 1'b1;
        end
        if (CW'(j_q) + CW'(1) < cnt_q) j_d = j_q + IW'(1);
        else begin
          i_d = i_q + IW'(1); j_d = i_q + IW'(2);
          if (CW'(i_q) + CW'(2) >= cnt_q) j_d = '0;
        end
        state_d = mdis_pkg::StCfI;
      end
      // subset walk: each interval is read, then checked
      mdis_pkg::StEnum: begin
        addr = i_q; state_d = mdis_pkg::StEnumChk;
      end
      mdis_pkg::StEnumChk: begin
        if (cand_q[i_q]) begin
          if ((conf_q[i_q] & cand_q) != '0) ok_d = 1'b0;
          sum_d = sum_q + dur; pc_d = pc_q + CW'(1);
        end
        if (CW'(i_q) + CW'(1) < cnt_q) begin
          i_d = i_q + IW'(1); state_d = mdis_pkg::StEnum;
        end else state_d = mdis_pkg::StDecide;
      end
      mdis_pkg::StDecide: begin
        if (ok_q && $signed(sum_q) > 0 &&
            (best_q == '0 || $signed(sum_q) > $signed(bsum_q) ||
             (sum_q == bsum_q && (pc_q > pb_q ||
              (pc_q == pb_q && (cand_q & lowb) != '0))))) begin
          best_d = cand_q; bsum_d = sum_q; pb_d = pc_q;
        end
        if ((cand_q | ~((N'(1) << cnt_q) - N'(1))) == '1 ||
            (cnt_q == CW'(N) && cand_q == '1)) begin
          if (best_d == '0) state_d = mdis_pkg::StNone;
          else begin
            i_d = '0; k_d = '0; state_d = mdis_pkg::StEmitRd;
          end
        end else begin
          cand_d = cand_q + N'(1); i_d = '0; sum_d = '0; ok_d = 1'b1; pc_d = '0;
          state_d = mdis_pkg::StEnum;
        end
      end
      mdis_pkg::StEmitRd: begin
        if (!best_q[i_q]) i_d = i_q + IW'(1);
        else begin
          addr = i_q; state_d = mdis_pkg::StEmitWait;
        end
      end
      mdis_pkg::StEmitWait: begin
        state_d = mdis_pkg::StEmit;
        si_d = rs; ei_d = re;
      end
      mdis_pkg::StEmit: begin
        if (out_free) begin
          ovl_d = 1'b1;
          od_d.sel_start = 16'(si_q); od_d.sel_end = 16'(ei_q);
          od_d.best_total = tot_sat[SW-1:0];
          od_d.none_found = 1'b0; od_d.overflow = ov_q;
          od_d.final_res = (k_q + CW'(1) == pb_q) || (k_q + CW'(1) == CW'(16));
          k_d = k_q + CW'(1);
          if (od_d.final_res) begin
            cnt_d = '0; ovf_d = 1'b0; state_d = mdis_pkg::StLoad;
          end else begin
            i_d = i_q + IW'(1); state_d = mdis_pkg::StEmitRd;
          end
        end
      end
      mdis_pkg::StNone: begin
        if (out_free) begin
          ovl_d = 1'b1;
          od_d = '0; od_d.none_found = 1'b1; od_d.overflow = ov_q;
          od_d.final_res = 1'b1;
          cnt_d = '0; ovf_d = 1'b0; state_d = mdis_pkg::StLoad;
        end
      end
      default: state_d = mdis_pkg::StLoad;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mdis_pkg::StLoad;
      cnt_q <= '0; ovf_q <= 1'b0; ovl_q <= 1'b0;
      best_q <= '0; bsum_q <= '0; cand_q <= '0;
    end else begin
      state_q <= state_d; cnt_q <= cnt_d; ovf_q <= ovf_d; ovl_q <= ovl_d;
      best_q <= best_d; bsum_q <= bsum_d; cand_q <= cand_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q <= i_d; j_q <= j_d; conf_q <= conf_d; si_q <= si_d; ei_q <= ei_d;
    sum_q <= sum_d; ok_q <= ok_d; pc_q <= pc_d; pb_q <= pb_d;
    k_q <= k_d; ov_q <= ov_d; od_q <= od_d;
  end

  assign out_valid_o = ovl_q;
  assign out_data_o  = od_q;

  // no item is taken while a search or its results are under way
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> (state_q == mdis_pkg::StLoad))
    else $error("input taken outside loading");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> $stable(out_data_o))
    else $error("output changed under stall");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(N))
    else $error("store count beyond capacity");
endmodule
`default_nettype wire

/* sim/mdis_checker.sv */
// checker for the max-duration interval selection unit: watches both channels,
// predicts the selected intervals and compares them. depends on mdis_pkg
`default_nettype none
module mdis_checker (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  input  wire logic                in_ready_i,
  input  wire mdis_pkg::in_item_t  in_data_i,
  input  wire logic                out_valid_i,
  input  wire logic                out_ready_i,
  input  wire mdis_pkg::out_item_t out_data_i,
  output int                       fail_count_o,
  output int                       pending_o
);
  import mdis_pkg::*;

  logic [15:0] iv_start [MaxIntervals];
  logic [15:0] iv_end   [MaxIntervals];
  int          iv_count;
  bit          dropped;
  out_item_t   selection_q[$];

  assign pending_o = selection_q.size();

  function automatic int popcount16(logic [15:0] m);
    int c;
    c = 0;
    for (int i = 0; i < 16; i++) c += m[i];
    return c;
  endfunction

  // exhaustive subset search, pushes the selected intervals in index order
  function automatic void select_intervals();
    logic [15:0] clash [MaxIntervals];
    longint      span  [MaxIntervals];
    logic [15:0] best, cand, diff;
    longint      best_sum, sum;
    bit          found, ok;
    int          k, nsel;
    out_item_t   r;
    best = '0;
    best_sum = 0;
    found = 0;
    for (int i = 0; i < iv_count; i++) begin
      clash[i] = '0;
      span[i]  = longint'(iv_end[i]) - longint'(iv_start[i]);
    end
    for (int i = 0; i < iv_count; i++)
      for (int j = i + 1; j < iv_count; j++)
        if (iv_start[i] < iv_end[j] && iv_start[j] < iv_end[i]) begin
          clash[i][j] = 1'b1;
          clash[j][i] = 1'b1;
        end
    for (int m = 1; m < (1 << iv_count); m++) begin
      cand = m[15:0];
      sum = 0;
      ok = 1;
      for (int i = 0; i < iv_count; i++)
        if (cand[i]) begin
          if ((clash[i] & cand) != 0) ok = 0;
          sum += span[i];
        end
      if (!ok || sum <= 0) continue;
      if (found && sum < best_sum) continue;
      if (found && sum == best_sum) begin
        diff = cand ^ best;
        if (popcount16(cand) < popcount16(best)) continue;
        // equal size: the lowest differing index decides
        if (popcount16(cand) == popcount16(best) && (cand & diff & (~diff + 1'b1)) == 0)
          continue;
      end
      found = 1;
      best = cand;
      best_sum = sum;
    end
    if (!found) begin
      r = '0;
      r.none_found = 1'b1;
      r.overflow = dropped;
      r.final_res = 1'b1;
      selection_q.push_back(r);
      return;
    end
    nsel = popcount16(best);
    k = 0;
    for (int i = 0; i < iv_count; i++)
      if (best[i]) begin
        k++;
        r.sel_start  = iv_start[i];
        r.sel_end    = iv_end[i];
        r.best_total = (best_sum > 1048575) ? 21'h0FFFFF : best_sum[20:0];
        r.none_found = 1'b0;
        r.overflow   = dropped;
        r.final_res  = (k == nsel);
        selection_q.push_back(r);
      end
  endfunction

  // handshakes are judged on the falling edge ahead of the rising edge that takes them
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iv_count = 0;
      dropped = 0;
      selection_q.delete();
      fail_count_o = 0;
    end else begin
      if (in_valid_i && in_ready_i) begin
        if (iv_count < MaxIntervals) begin
          iv_start[iv_count] = in_data_i.start_time;
          iv_end[iv_count]   = in_data_i.end_time;
          iv_count++;
        end else begin
          dropped = 1;
        end
        if (in_data_i.last) begin
          select_intervals();
          iv_count = 0;
          dropped = 0;
        end
      end
      if (out_valid_i && out_ready_i) begin
        if (selection_q.size() == 0) begin
          $error("unexpected result item %p", out_data_i);
          fail_count_o++;
        end else begin
          out_item_t exp_r;
          exp_r = selection_q.pop_front();
          if (out_data_i.sel_start !== exp_r.sel_start) begin
            $error("sel_start: expected %0d, got %0d", exp_r.sel_start, out_data_i.sel_start);
            fail_count_o++;
          end
          if (out_data_i.sel_end !== exp_r.sel_end) begin
            $error("sel_end: expected %0d, got %0d", exp_r.sel_end, out_data_i.sel_end);
            fail_count_o++;
          end
          if (out_data_i.best_total !== exp_r.best_total) begin
            $error("best_total: expected %0d, got %0d", exp_r.best_total,
                   out_data_i.best_total);
            fail_count_o++;
          end
          if (out_data_i.none_found !== exp_r.none_found) begin
            $error("none_found: expected %0b, got %0b", exp_r.none_found,
                   out_data_i.none_found);
            fail_count_o++;
          end
          if (out_data_i.overflow !== exp_r.overflow) begin
            $error("overflow: expected %0b, got %0b", exp_r.overflow, out_data_i.overflow);
            fail_count_o++;
          end
          if (out_data_i.final_res !== exp_r.final_res) begin
            $error("final_res: expected %0b, got %0b", exp_r.final_res, out_data_i.final_res);
            fail_count_o++;
          end
        end
      end
    end
  end
endmodule
`default_nettype wire

/* sim/max_duration_interval_selection_unit_test.sv */
// testbench top for the max-duration interval selection unit: drives interval
// sets, stalls the result channel and gives the verdict. depends on mdis_pkg,
// the unit and mdis_checker
`default_nettype none
module max_duration_interval_selection_unit_test;
  import mdis_pkg::*;

  localparam int StallLimit = 10000000;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;
  int        fail_count, pending;
  int        send_idle = 30, recv_idle = 56;
  int        quiet_cycles = 0;

  always #5 clk_i = ~clk_i;

  max_duration_interval_selection_unit DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_data_o(out_data)
  );

  mdis_checker u_checker (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_ready_i(in_ready), .in_data_i(in_data),
    .out_valid_i(out_valid), .out_ready_i(out_ready), .out_data_i(out_data),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always @(posedge clk_i) out_ready <= ($urandom_range(99) >= recv_idle);

  // watchdog: its limit allows for a full sixteen-interval search, during which no handshake is seen
  always @(negedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic send_interval(input logic [15:0] s, input logic [15:0] e, input bit fin);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= '{start_time: s, end_time: e, last: fin};
    do @(negedge clk_i); while (!in_ready);
    @(posedge clk_i);
  endtask

  task automatic send_random_set(input int n);
    bit coarse;
    logic [15:0] s, e;
    coarse = ($urandom_range(2) == 0);
    for (int i = 0; i < n; i++) begin
      if (coarse) begin
        s = 16'($urandom);
        e = 16'($urandom);
      end else begin
        // small times so that sets have real structure and ties
        s = 16'($urandom_range(60));
        e = ($urandom_range(9) == 0) ? s - 16'($urandom_range(5)) :
                                       s + 16'($urandom_range(20));
      end
      send_interval(s, e, i == n - 1);
    end
  endtask

  initial begin
    int sent, n;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_interval(16'd5, 16'd5, 1'b1);          // zero length: nothing qualifies
    send_interval(16'd100, 16'd10, 1'b1);       // reversed alone
    send_interval(16'd0, 16'hFFFF, 1'b1);       // widest interval
    send_interval(16'd0, 16'd10, 1'b0);         // equal total, more items win
    send_interval(16'd10, 16'd20, 1'b0);
    send_interval(16'd0, 16'd20, 1'b1);
    send_interval(16'd0, 16'd10, 1'b0);         // equal total and size, lower index
    send_interval(16'd5, 16'd15, 1'b1);
    send_interval(16'd50, 16'd40, 1'b0);        // reversed item clashes with the wide one, which wins alone
    send_interval(16'd0, 16'd100, 1'b1);
    // full store, then a dropped item that starts the search
    for (int i = 0; i < MaxIntervals; i++)
      send_interval(16'($urandom), 16'($urandom), 1'b0);
    send_interval(16'($urandom), 16'($urandom), 1'b1);

    sent = 0;
    while (sent < 143) begin
      if (sent < 48) begin
        send_idle = 30; recv_idle = 56;
      end else if (sent < 96) begin
        send_idle = 56; recv_idle = 30;
      end else begin
        send_idle = 0; recv_idle = 0;
      end
      n = ($urandom_range(7) == 0) ? $urandom_range(9, 10) : $urandom_range(1, 7);
      send_random_set(n);
      sent += n;
    end
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (fail_count == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end
endmodule
`default_nettype wire
